[rtl/pcog_pkg.sv]
// pcog_pkg: shared constants, codes and types of the occupancy grid block
// no dependencies; imported by pcog_div, pcog_cfg and point_cloud_occupancy_grid
`timescale 1ns / 1ps

package pcog_pkg;

	// grid geometry
	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int MAX_GROW  = 15;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int ADDR_W    = COL_W + ROW_W;
	localparam int DEPTH     = 1 << ADDR_W;
	localparam int GRID_W    = 9;
	localparam int RAD_W     = $clog2(MAX_GROW + 1);
	localparam int OFF_W     = RAD_W + 1;
	localparam int D2_W      = 2 * OFF_W;

	// field widths
	localparam int PT_W      = 24;
	localparam int ORG_W     = 25;

	// divider sizes: span plus padding plus rounding fits in 25 bits
	localparam int DIV_W     = 25;
	localparam int DVS_W     = 11;

	// empty bounding box
	localparam logic signed [PT_W-1:0] BOX_HI = 24'sh7FFFFF;
	localparam logic signed [PT_W-1:0] BOX_LO = 24'sh800000;

	// map bytes
	localparam logic [7:0] CELL_OCC     = 8'd0;
	localparam logic [7:0] CELL_UNKNOWN = 8'd205;
	localparam logic [7:0] CELL_FREE    = 8'd254;

	// function codes
	localparam logic [2:0] FN_CLEAR  = 3'd0;
	localparam logic [2:0] FN_BOUNDS = 3'd1;
	localparam logic [2:0] FN_BIN    = 3'd2;
	localparam logic [2:0] FN_BUILD  = 3'd3;
	localparam logic [2:0] FN_READ   = 3'd4;

	// status codes
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_SAT   = 2'd1;
	localparam logic [1:0] STS_OUT   = 2'd2;
	localparam logic [1:0] STS_EMPTY = 2'd3;

	// register indexes
	localparam logic [2:0] REG_RES       = 3'd0;
	localparam logic [2:0] REG_PAD       = 3'd1;
	localparam logic [2:0] REG_FLOOR_LO  = 3'd2;
	localparam logic [2:0] REG_FLOOR_HI  = 3'd3;
	localparam logic [2:0] REG_OBST_LO   = 3'd4;
	localparam logic [2:0] REG_OBST_HI   = 3'd5;
	localparam logic [2:0] REG_FREE_GROW = 3'd6;
	localparam logic [2:0] REG_OBST_GROW = 3'd7;

	typedef struct packed {
		logic [9:0]         resolution;
		logic [13:0]        padding;
		logic signed [17:0] floor_lo;
		logic signed [17:0] floor_hi;
		logic signed [17:0] obst_lo;
		logic signed [17:0] obst_hi;
		logic [13:0]        free_grow;
		logic [13:0]        obst_grow;
	} cfg_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_COLS,
		S_DIV_ROWS,
		S_DIV_GX,
		S_DIV_GY,
		S_BIN_RD,
		S_BIN_WR,
		S_DIV_RF,
		S_DIV_RO,
		S_DST_CLR,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DIL,
		S_RD_ISSUE,
		S_RD_DATA
	} state_t;

endpackage

[rtl/pcog_ram.sv]
// pcog_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module pcog_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/pcog_div.sv]
// pcog_div: restoring divider, one quotient bit per cycle
// depends on pcog_pkg
`timescale 1ns / 1ps

module pcog_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [pcog_pkg::DIV_W-1:0] num,
	input  logic [pcog_pkg::DVS_W-1:0] den,
	output logic                       done,
	output logic [pcog_pkg::DIV_W-1:0] quo
);

	import pcog_pkg::*;

	logic                     run_q;
	logic                     done_q;
	logic [$clog2(DIV_W)-1:0] cnt_q;
	logic [DIV_W-1:0]         num_q;
	logic [DVS_W-1:0]         rem_q;
	logic [DVS_W-1:0]         den_q;
	logic [DVS_W:0]           rem_sh;
	logic                     ge;
	logic [DVS_W:0]           rem_sub;

	// one trial subtraction
	always_comb begin
		rem_sh  = {rem_q, num_q[DIV_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// iteration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				num_q <= num;
				rem_q <= '0;
				den_q <= den;
			end else if (run_q) begin
				num_q <= {num_q[DIV_W-2:0], ge};
				rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_W))'(DIV_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

[rtl/pcog_cfg.sv]
// pcog_cfg: apb register file holding resolution, padding, bands and grow radii
// depends on pcog_pkg
`timescale 1ns / 1ps

module pcog_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output pcog_pkg::cfg_t     cfg
);

	import pcog_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resolution <= 10'd50;
			cfg_q.padding    <= 14'd500;
			cfg_q.floor_lo   <= -18'sd300;
			cfg_q.floor_hi   <= 18'sd50;
			cfg_q.obst_lo    <= 18'sd50;
			cfg_q.obst_hi    <= 18'sd1200;
			cfg_q.free_grow  <= 14'd100;
			cfg_q.obst_grow  <= 14'd300;
		end else if (wr) begin
			unique case (idx)
				REG_RES:       cfg_q.resolution <= pwdata[9:0];
				REG_PAD:       cfg_q.padding    <= pwdata[13:0];
				REG_FLOOR_LO:  cfg_q.floor_lo   <= pwdata[17:0];
				REG_FLOOR_HI:  cfg_q.floor_hi   <= pwdata[17:0];
				REG_OBST_LO:   cfg_q.obst_lo    <= pwdata[17:0];
				REG_OBST_HI:   cfg_q.obst_hi    <= pwdata[17:0];
				REG_FREE_GROW: cfg_q.free_grow  <= pwdata[13:0];
				REG_OBST_GROW: cfg_q.obst_grow  <= pwdata[13:0];
				default: begin
				end
			endcase
		end
	end

	// read mux, signed bands sign extended
	always_comb begin
		unique case (idx)
			REG_RES:       prdata = {22'd0, cfg_q.resolution};
			REG_PAD:       prdata = {18'd0, cfg_q.padding};
			REG_FLOOR_LO:  prdata = {{14{cfg_q.floor_lo[17]}}, cfg_q.floor_lo};
			REG_FLOOR_HI:  prdata = {{14{cfg_q.floor_hi[17]}}, cfg_q.floor_hi};
			REG_OBST_LO:   prdata = {{14{cfg_q.obst_lo[17]}}, cfg_q.obst_lo};
			REG_OBST_HI:   prdata = {{14{cfg_q.obst_hi[17]}}, cfg_q.obst_hi};
			REG_FREE_GROW: prdata = {18'd0, cfg_q.free_grow};
			REG_OBST_GROW: prdata = {18'd0, cfg_q.obst_grow};
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/point_cloud_occupancy_grid.sv]
// point_cloud_occupancy_grid: top level, sequencer around the mask memories
// depends on pcog_pkg, pcog_cfg, pcog_div, pcog_ram
//
//  channel   signals                                          transfer
//  ------    -----------------------------------------------  ------------------------
//  config    psel penable pwrite paddr pwdata prdata pready   psel&penable&pwrite
//  item      start busy func point_*_mm cell_col cell_row     start & !busy
//  result    done cell_value map_* origin_*_mm status         done, one cycle
//
//  bin runs up to four serial divisions in the shared divider; clear writes one ram
//  row per cycle; build runs four divisions unless the box is empty, clears the
//  output masks, scans every grid cell and walks a (2r+1)^2 square per marked cell.
//  after reset a clearing pass over the whole memory runs with busy high.
//  one item at a time; results leave through output registers and cannot stall.
`timescale 1ns / 1ps

module point_cloud_occupancy_grid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [23:0] point_x_mm,
	input  logic signed [23:0] point_y_mm,
	input  logic signed [23:0] point_z_mm,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         cell_row,
	output logic               done,
	output logic [7:0]         cell_value,
	output logic [8:0]         map_width,
	output logic [8:0]         map_height,
	output logic signed [24:0] origin_x_mm,
	output logic signed [24:0] origin_y_mm,
	output logic [1:0]         status
);

	import pcog_pkg::*;

	cfg_t cfg;

	state_t state_q, state_d;

	// item registers
	logic [2:0]               func_q;
	logic signed [PT_W-1:0]   px_q, py_q, pz_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;

	// map state
	logic signed [PT_W-1:0]   box_min_x_q, box_min_y_q, box_max_x_q, box_max_y_q;
	logic [GRID_W-1:0]        grid_cols_q, grid_rows_q;
	logic [GRID_W-1:0]        tcols_q, trows_q;
	logic                     sat_q;
	logic [1:0]               stat_q;
	logic                     clr_rsp_q;
	logic [ADDR_W-1:0]        clr_q;
	logic [COL_W-1:0]         gx_q;
	logic                     gxo_q;
	logic [ROW_W-1:0]         gy_q;
	logic [RAD_W-1:0]         rf_q, ro_q;

	// scan and dilation
	logic [COL_W-1:0]         sx_q;
	logic [ROW_W-1:0]         sy_q;
	logic signed [OFF_W-1:0]  offx_q, offy_q;
	logic [1:0]               bits_q;
	logic                     wv_s1;
	logic [ADDR_W-1:0]        waddr_s1;
	logic [1:0]               wmask_s1;

	// result registers
	logic                     done_q;
	logic [7:0]               cell_q;
	logic [1:0]               status_q;

	// divider
	logic                     div_go, div_done, div_pend_q;
	logic [DIV_W-1:0]         div_num, div_quo;
	logic [DVS_W-1:0]         div_den;

	// memories: src {obstacle, floor}, dst {inflated, free}
	logic                     src_we, dst_we;
	logic [ADDR_W-1:0]        src_waddr, src_raddr, dst_waddr, dst_raddr;
	logic [1:0]               src_wdata, src_rdata, dst_wdata, dst_rdata;

	// combinational helpers
	logic                     accept, box_empty;
	logic [9:0]               res_eff;
	logic signed [ORG_W-1:0]  org_x, org_y;
	logic [DIV_W-1:0]         span_x, span_y, cnum_x, cnum_y;
	logic [DIV_W:0]           dxs, dys;
	logic [1:0]               band;
	logic [RAD_W-1:0]         rmax;
	logic signed [OFF_W-1:0]  rmax_s;
	logic [2*RAD_W-1:0]       rf2, ro2;
	logic [COL_W+1:0]         nx;
	logic [ROW_W+1:0]         ny;
	logic                     n_ok;
	logic [D2_W-1:0]          d2;
	logic [1:0]               nmask;
	logic                     dil_issue;
	logic                     x_last, y_last, offx_end, offy_end;
	logic [DIV_W-1:0]         q_cols_lim, q_rows_lim, q_grow_lim;
	logic                     fin;
	logic [1:0]               fin_status;
	logic [7:0]               fin_cell;

	pcog_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pcog_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	pcog_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_src_ram (
		.clk   (clk),
		.we    (src_we),
		.waddr (src_waddr),
		.wdata (src_wdata),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	pcog_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_dst_ram (
		.clk   (clk),
		.we    (dst_we),
		.waddr (dst_waddr),
		.wdata (dst_wdata),
		.raddr (dst_raddr),
		.rdata (dst_rdata)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// geometry from the box and the registers
	always_comb begin
		res_eff   = (cfg.resolution == 10'd0) ? 10'd1 : cfg.resolution;
		box_empty = (box_min_x_q > box_max_x_q) || (box_min_y_q > box_max_y_q);
		org_x     = $signed({box_min_x_q[PT_W-1], box_min_x_q}) - $signed({11'd0, cfg.padding});
		org_y     = $signed({box_min_y_q[PT_W-1], box_min_y_q}) - $signed({11'd0, cfg.padding});
		span_x    = {box_max_x_q[PT_W-1], box_max_x_q} - {box_min_x_q[PT_W-1], box_min_x_q};
		span_y    = {box_max_y_q[PT_W-1], box_max_y_q} - {box_min_y_q[PT_W-1], box_min_y_q};
		cnum_x    = span_x + {10'd0, cfg.padding, 1'b0} + {15'd0, res_eff} - 25'd1;
		cnum_y    = span_y + {10'd0, cfg.padding, 1'b0} + {15'd0, res_eff} - 25'd1;
		dxs       = {px_q[PT_W-1], px_q[PT_W-1], px_q} - {org_x[ORG_W-1], org_x};
		dys       = {py_q[PT_W-1], py_q[PT_W-1], py_q} - {org_y[ORG_W-1], org_y};
		band[0]   = ($signed(pz_q) >= $signed(cfg.floor_lo)) &&
		            ($signed(pz_q) <= $signed(cfg.floor_hi));
		band[1]   = ($signed(pz_q) >= $signed(cfg.obst_lo)) &&
		            ($signed(pz_q) <= $signed(cfg.obst_hi));
		q_cols_lim = DIV_W'(MAX_COLS);
		q_rows_lim = DIV_W'(MAX_ROWS);
		q_grow_lim = DIV_W'(MAX_GROW);
	end

	// divider operand select
	always_comb begin
		div_num = cnum_x;
		div_den = {1'b0, res_eff};
		case (state_q)
			S_DIV_ROWS: div_num = cnum_y;
			S_DIV_GX:   div_num = dxs[DIV_W-1:0];
			S_DIV_GY:   div_num = dys[DIV_W-1:0];
			S_DIV_RF: begin
				div_num = DIV_W'({cfg.free_grow, 1'b0}) + DIV_W'(res_eff);
				div_den = {res_eff, 1'b0};
			end
			S_DIV_RO: begin
				div_num = DIV_W'({cfg.obst_grow, 1'b0}) + DIV_W'(res_eff);
				div_den = {res_eff, 1'b0};
			end
			default: begin
			end
		endcase
		div_go = !div_pend_q && (state_q == S_DIV_COLS || state_q == S_DIV_ROWS ||
		         state_q == S_DIV_GX || state_q == S_DIV_GY ||
		         state_q == S_DIV_RF || state_q == S_DIV_RO);
	end

	// disk offset of the current neighbor
	always_comb begin
		rmax     = (rf_q > ro_q) ? rf_q : ro_q;
		rmax_s   = $signed({1'b0, rmax});
		rf2      = rf_q * rf_q;
		ro2      = ro_q * ro_q;
		nx       = {2'b00, sx_q} + {{(COL_W+2-OFF_W){offx_q[OFF_W-1]}}, offx_q};
		ny       = {2'b00, sy_q} + {{(ROW_W+2-OFF_W){offy_q[OFF_W-1]}}, offy_q};
		n_ok     = !nx[COL_W+1] && !ny[ROW_W+1] &&
		           (nx[COL_W:0] < grid_cols_q) && (ny[ROW_W:0] < grid_rows_q);
		d2       = D2_W'(offx_q * offx_q) + D2_W'(offy_q * offy_q);
		nmask[0] = bits_q[0] && (d2 <= D2_W'(rf2));
		nmask[1] = bits_q[1] && (d2 <= D2_W'(ro2));
		dil_issue = (state_q == S_DIL) && n_ok && (nmask != 2'b00);
		offx_end = (offx_q == rmax_s);
		offy_end = (offy_q == rmax_s);
		x_last   = ({1'b0, sx_q} + 9'd1) == grid_cols_q;
		y_last   = ({1'b0, sy_q} + 9'd1) == grid_rows_q;
	end

	// memory ports
	always_comb begin
		src_we    = 1'b0;
		src_waddr = clr_q;
		src_wdata = 2'b00;
		src_raddr = {sy_q, sx_q};
		dst_we    = 1'b0;
		dst_waddr = clr_q;
		dst_wdata = 2'b00;
		dst_raddr = {row_q, col_q};
		if (state_q == S_CLEAR) begin
			src_we = 1'b1;
			dst_we = 1'b1;
		end else if (state_q == S_DST_CLR) begin
			dst_we = 1'b1;
		end else if (wv_s1) begin
			// read-modify-write of a dilated cell, read issued in the cycle before
			dst_we    = 1'b1;
			dst_waddr = waddr_s1;
			dst_wdata = dst_rdata | wmask_s1;
		end
		if (state_q == S_BIN_RD || state_q == S_BIN_WR) begin
			src_raddr = {gy_q, gx_q};
		end
		if (state_q == S_BIN_WR) begin
			src_we    = 1'b1;
			src_waddr = {gy_q, gx_q};
			src_wdata = src_rdata | band;
		end
		if (state_q == S_DIL) begin
			dst_raddr = {ny[ROW_W-1:0], nx[COL_W-1:0]};
		end
	end

	// next state and result
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = STS_OK;
		fin_cell   = CELL_OCC;
		unique case (state_q)
			S_CLEAR: begin
				if (&clr_q) begin
					state_d = S_IDLE;
					fin     = clr_rsp_q;
				end
			end
			S_IDLE: begin
				if (start) begin
					case (func)
						FN_CLEAR: state_d = S_CLEAR;
						FN_BOUNDS: fin = 1'b1;
						FN_BIN: begin
							if (box_empty) begin
								fin        = 1'b1;
								fin_status = STS_EMPTY;
							end else begin
								state_d = S_DIV_COLS;
							end
						end
						FN_BUILD: state_d = box_empty ? S_DST_CLR : S_DIV_COLS;
						FN_READ: begin
							if ({1'b0, cell_col} >= grid_cols_q ||
							    {1'b0, cell_row} >= grid_rows_q) begin
								fin        = 1'b1;
								fin_status = STS_OUT;
								fin_cell   = CELL_UNKNOWN;
							end else begin
								state_d = S_RD_ISSUE;
							end
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_DIV_COLS: begin
				if (div_done) begin
					state_d = S_DIV_ROWS;
				end
			end
			S_DIV_ROWS: begin
				if (div_done) begin
					if (func_q == FN_BUILD) begin
						state_d = S_DIV_RF;
					end else if (dxs[DIV_W] || dys[DIV_W]) begin
						state_d    = S_IDLE;
						fin        = 1'b1;
						fin_status = STS_OUT;
					end else begin
						state_d = S_DIV_GX;
					end
				end
			end
			S_DIV_GX: begin
				if (div_done) begin
					state_d = S_DIV_GY;
				end
			end
			S_DIV_GY: begin
				if (div_done) begin
					if (gxo_q || div_quo >= DIV_W'(trows_q)) begin
						state_d    = S_IDLE;
						fin        = 1'b1;
						fin_status = STS_OUT;
					end else begin
						state_d = S_BIN_RD;
					end
				end
			end
			S_BIN_RD: state_d = S_BIN_WR;
			S_BIN_WR: begin
				state_d    = S_IDLE;
				fin        = 1'b1;
				fin_status = sat_q ? STS_SAT : STS_OK;
			end
			S_DIV_RF: begin
				if (div_done) begin
					state_d = S_DIV_RO;
				end
			end
			S_DIV_RO: begin
				if (div_done) begin
					state_d = S_DST_CLR;
				end
			end
			S_DST_CLR: begin
				if (&clr_q) begin
					if (grid_cols_q == '0 || grid_rows_q == '0) begin
						state_d    = S_IDLE;
						fin        = 1'b1;
						fin_status = stat_q;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (src_rdata != 2'b00) begin
					state_d = S_DIL;
				end else if (x_last && y_last) begin
					state_d    = S_IDLE;
					fin        = 1'b1;
					fin_status = stat_q;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_DIL: begin
				if (offx_end && offy_end) begin
					if (x_last && y_last) begin
						state_d    = S_IDLE;
						fin        = 1'b1;
						fin_status = stat_q;
					end else begin
						state_d = S_SCAN_RD;
					end
				end
			end
			S_RD_ISSUE: state_d = S_RD_DATA;
			S_RD_DATA: begin
				state_d  = S_IDLE;
				fin      = 1'b1;
				fin_cell = dst_rdata[1] ? CELL_OCC : (dst_rdata[0] ? CELL_FREE : CELL_UNKNOWN);
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q      <= FN_CLEAR;
			px_q        <= '0;
			py_q        <= '0;
			pz_q        <= '0;
			col_q       <= '0;
			row_q       <= '0;
			box_min_x_q <= BOX_HI;
			box_min_y_q <= BOX_HI;
			box_max_x_q <= BOX_LO;
			box_max_y_q <= BOX_LO;
			grid_cols_q <= '0;
			grid_rows_q <= '0;
			tcols_q     <= '0;
			trows_q     <= '0;
			sat_q       <= 1'b0;
			stat_q      <= STS_OK;
			clr_rsp_q   <= 1'b0;
			clr_q       <= '0;
			gx_q        <= '0;
			gxo_q       <= 1'b0;
			gy_q        <= '0;
			rf_q        <= '0;
			ro_q        <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			offx_q      <= '0;
			offy_q      <= '0;
			bits_q      <= '0;
			wv_s1       <= 1'b0;
			waddr_s1    <= '0;
			wmask_s1    <= '0;
			div_pend_q  <= 1'b0;
			done_q      <= 1'b0;
			cell_q      <= '0;
			status_q    <= STS_OK;
		end else begin
			// result strobe
			done_q   <= fin;
			cell_q   <= fin_cell;
			status_q <= fin_status;

			// divider handshake
			if (div_go) begin
				div_pend_q <= 1'b1;
			end else if (div_done) begin
				div_pend_q <= 1'b0;
			end

			// dilation write stage
			wv_s1    <= dil_issue;
			waddr_s1 <= {ny[ROW_W-1:0], nx[COL_W-1:0]};
			wmask_s1 <= nmask;

			// clearing sweep counter
			if (state_q == S_CLEAR || state_q == S_DST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func;
						px_q   <= point_x_mm;
						py_q   <= point_y_mm;
						pz_q   <= point_z_mm;
						col_q  <= cell_col;
						row_q  <= cell_row;
						sat_q  <= 1'b0;
						clr_q  <= '0;
						case (func)
							FN_CLEAR: begin
								box_min_x_q <= BOX_HI;
								box_min_y_q <= BOX_HI;
								box_max_x_q <= BOX_LO;
								box_max_y_q <= BOX_LO;
								grid_cols_q <= '0;
								grid_rows_q <= '0;
								clr_rsp_q   <= 1'b1;
							end
							FN_BOUNDS: begin
								if (point_x_mm < box_min_x_q) box_min_x_q <= point_x_mm;
								if (point_y_mm < box_min_y_q) box_min_y_q <= point_y_mm;
								if (point_x_mm > box_max_x_q) box_max_x_q <= point_x_mm;
								if (point_y_mm > box_max_y_q) box_max_y_q <= point_y_mm;
							end
							FN_BUILD: begin
								if (box_empty) begin
									grid_cols_q <= '0;
									grid_rows_q <= '0;
									stat_q      <= STS_EMPTY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DIV_COLS: begin
					if (div_done) begin
						tcols_q <= (div_quo > q_cols_lim) ? GRID_W'(MAX_COLS) : div_quo[GRID_W-1:0];
						if (div_quo > q_cols_lim) sat_q <= 1'b1;
						if (func_q == FN_BUILD) begin
							grid_cols_q <= (div_quo > q_cols_lim) ? GRID_W'(MAX_COLS) :
							               div_quo[GRID_W-1:0];
						end
					end
				end
				S_DIV_ROWS: begin
					if (div_done) begin
						trows_q <= (div_quo > q_rows_lim) ? GRID_W'(MAX_ROWS) : div_quo[GRID_W-1:0];
						if (div_quo > q_rows_lim) sat_q <= 1'b1;
						if (func_q == FN_BUILD) begin
							grid_rows_q <= (div_quo > q_rows_lim) ? GRID_W'(MAX_ROWS) :
							               div_quo[GRID_W-1:0];
						end
					end
				end
				S_DIV_GX: begin
					if (div_done) begin
						gx_q  <= div_quo[COL_W-1:0];
						gxo_q <= div_quo >= DIV_W'(tcols_q);
					end
				end
				S_DIV_GY: begin
					if (div_done) begin
						gy_q <= div_quo[ROW_W-1:0];
					end
				end
				S_DIV_RF: begin
					if (div_done) begin
						rf_q <= (div_quo > q_grow_lim) ? RAD_W'(MAX_GROW) : div_quo[RAD_W-1:0];
						if (div_quo > q_grow_lim) sat_q <= 1'b1;
					end
				end
				S_DIV_RO: begin
					if (div_done) begin
						ro_q   <= (div_quo > q_grow_lim) ? RAD_W'(MAX_GROW) : div_quo[RAD_W-1:0];
						stat_q <= (sat_q || div_quo > q_grow_lim) ? STS_SAT : STS_OK;
						sx_q   <= '0;
						sy_q   <= '0;
					end
				end
				S_SCAN_CHK: begin
					if (src_rdata != 2'b00) begin
						bits_q <= src_rdata;
						offx_q <= -rmax_s;
						offy_q <= -rmax_s;
					end else if (x_last) begin
						sx_q <= '0;
						sy_q <= sy_q + 1'b1;
					end else begin
						sx_q <= sx_q + 1'b1;
					end
				end
				S_DIL: begin
					// walk the square around the cell, row by row
					if (offx_end) begin
						offx_q <= -rmax_s;
						if (offy_end) begin
							if (x_last) begin
								sx_q <= '0;
								sy_q <= sy_q + 1'b1;
							end else begin
								sx_q <= sx_q + 1'b1;
							end
						end else begin
							offy_q <= offy_q + 1'b1;
						end
					end else begin
						offx_q <= offx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result ports
	assign done        = done_q;
	assign cell_value  = cell_q;
	assign status      = status_q;
	assign map_width   = grid_cols_q;
	assign map_height  = grid_rows_q;
	assign origin_x_mm = box_empty ? '0 : org_x;
	assign origin_y_mm = box_empty ? '0 : org_y;

endmodule

[bench/tb.sv]
// tb: self-checking bench for point_cloud_occupancy_grid, map predictor and result checker
// depends on pcog_pkg and the rtl of point_cloud_occupancy_grid
// drives config writes and command items with random gaps; compares every result in order
`timescale 1ns / 1ps

module tb;
	import pcog_pkg::*;

	typedef struct {
		logic [2:0]         fn;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [7:0]         col;
		logic [7:0]         row;
	} cmd_t;

	typedef struct {
		logic [7:0]  cval;
		logic [8:0]  w;
		logic [8:0]  h;
		logic [24:0] ox;
		logic [24:0] oy;
		logic [1:0]  st;
	} map_res_t;

	localparam int IDLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [2:0] func = '0;
	logic signed [23:0] point_x_mm = '0, point_y_mm = '0, point_z_mm = '0;
	logic [7:0] cell_col = '0, cell_row = '0;
	logic done;
	logic [7:0] cell_value;
	logic [8:0] map_width, map_height;
	logic signed [24:0] origin_x_mm, origin_y_mm;
	logic [1:0] status;

	point_cloud_occupancy_grid dut (.*);

	always #5 clk = ~clk;

	// shadow registers and map state
	int cfg_res, cfg_pad, cfg_flo, cfg_fhi, cfg_olo, cfg_ohi, cfg_fgrow, cfg_ogrow;
	int bmin_x, bmin_y, bmax_x, bmax_y, grid_c, grid_r;
	bit floor_m [0:65535];
	bit obst_m [0:65535];
	bit free_m [0:65535];
	bit infl_m [0:65535];

	cmd_t pending_cmds[$];
	map_res_t expected_maps[$];
	cmd_t cur;
	int n_pushed = 0, n_acc = 0, n_done = 0, drv_seen = 0, gap = 0;
	int errors = 0, shown = 0, idle_cycles = 0, n_settings = 0;
	bit burst;

	function automatic longint res_eff();
		return (cfg_res == 0) ? 1 : cfg_res;
	endfunction

	function automatic bit box_empty();
		return (bmin_x > bmax_x) || (bmin_y > bmax_y);
	endfunction

	function automatic int axis_cells(longint lo, longint hi, int limit, inout bit sat);
		longint span, n;
		span = hi - lo + 2 * cfg_pad;
		n = (span + res_eff() - 1) / res_eff();
		if (n > limit) begin
			sat = 1'b1;
			n = limit;
		end
		return int'(n);
	endfunction

	function automatic int grow_cells(int grow, inout bit sat);
		longint n;
		n = (2 * longint'(grow) + res_eff()) / (2 * res_eff());
		if (n > MAX_GROW) begin
			sat = 1'b1;
			n = MAX_GROW;
		end
		return int'(n);
	endfunction

	task automatic clear_masks(input bit all_four);
		for (int i = 0; i < 65536; i++) begin
			free_m[i] = 0;
			infl_m[i] = 0;
			if (all_four) begin
				floor_m[i] = 0;
				obst_m[i] = 0;
			end
		end
	endtask

	// disk dilation of floor (obst_src=0) or obstacle mask into its grown mask
	task automatic grow_mask(input bit obst_src, input int rad);
		bit s;
		int nx, ny;
		for (int y = 0; y < grid_r; y++)
			for (int x = 0; x < grid_c; x++) begin
				s = obst_src ? obst_m[y*MAX_COLS+x] : floor_m[y*MAX_COLS+x];
				if (s)
					for (int dy = -rad; dy <= rad; dy++)
						for (int dx = -rad; dx <= rad; dx++) begin
							nx = x + dx;
							ny = y + dy;
							if (dx*dx + dy*dy <= rad*rad && nx >= 0 && ny >= 0 &&
							    nx < grid_c && ny < grid_r) begin
								if (obst_src) infl_m[ny*MAX_COLS+nx] = 1;
								else free_m[ny*MAX_COLS+nx] = 1;
							end
						end
			end
	endtask

	// work out the result of one accepted command and queue it
	task automatic predict_map(input cmd_t c);
		map_res_t e;
		longint px, py, pz, dx, dy, gx, gy, ox, oy;
		int cols, rows, rf, ro, id;
		bit sat;
		px = c.x;
		py = c.y;
		pz = c.z;
		sat = 0;
		e.cval = '0;
		e.st = STS_OK;
		case (c.fn)
			FN_CLEAR: begin
				bmin_x = int'(BOX_HI);
				bmin_y = int'(BOX_HI);
				bmax_x = int'(BOX_LO);
				bmax_y = int'(BOX_LO);
				grid_c = 0;
				grid_r = 0;
				clear_masks(1);
			end
			FN_BOUNDS: begin
				if (px < bmin_x) bmin_x = int'(px);
				if (py < bmin_y) bmin_y = int'(py);
				if (px > bmax_x) bmax_x = int'(px);
				if (py > bmax_y) bmax_y = int'(py);
			end
			FN_BIN: begin
				if (box_empty()) begin
					e.st = STS_EMPTY;
				end else begin
					cols = axis_cells(bmin_x, bmax_x, MAX_COLS, sat);
					rows = axis_cells(bmin_y, bmax_y, MAX_ROWS, sat);
					dx = px - (longint'(bmin_x) - cfg_pad);
					dy = py - (longint'(bmin_y) - cfg_pad);
					if (dx < 0 || dy < 0) begin
						e.st = STS_OUT;
					end else begin
						gx = dx / res_eff();
						gy = dy / res_eff();
						if (gx >= cols || gy >= rows) begin
							e.st = STS_OUT;
						end else begin
							id = int'(gy) * MAX_COLS + int'(gx);
							if (pz >= cfg_flo && pz <= cfg_fhi) floor_m[id] = 1;
							if (pz >= cfg_olo && pz <= cfg_ohi) obst_m[id] = 1;
							e.st = sat ? STS_SAT : STS_OK;
						end
					end
				end
			end
			FN_BUILD: begin
				clear_masks(0);
				if (box_empty()) begin
					grid_c = 0;
					grid_r = 0;
					e.st = STS_EMPTY;
				end else begin
					grid_c = axis_cells(bmin_x, bmax_x, MAX_COLS, sat);
					grid_r = axis_cells(bmin_y, bmax_y, MAX_ROWS, sat);
					rf = grow_cells(cfg_fgrow, sat);
					ro = grow_cells(cfg_ogrow, sat);
					grow_mask(0, rf);
					grow_mask(1, ro);
					e.st = sat ? STS_SAT : STS_OK;
				end
			end
			FN_READ: begin
				if (c.col >= grid_c || c.row >= grid_r) begin
					e.cval = CELL_UNKNOWN;
					e.st = STS_OUT;
				end else begin
					id = c.row * MAX_COLS + c.col;
					e.cval = infl_m[id] ? CELL_OCC : (free_m[id] ? CELL_FREE : CELL_UNKNOWN);
				end
			end
			default: ;
		endcase
		ox = 0;
		oy = 0;
		if (!box_empty()) begin
			ox = longint'(bmin_x) - cfg_pad;
			oy = longint'(bmin_y) - cfg_pad;
		end
		e.w = grid_c[8:0];
		e.h = grid_r[8:0];
		e.ox = ox[24:0];
		e.oy = oy[24:0];
		expected_maps = {expected_maps, e};
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// command driver: holds start until the transfer, then idles or loads the next
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && n_acc != drv_seen) begin
				drv_seen = n_acc;
				gap = pick_gap();
				if (gap == 0 && pending_cmds.size() > 0) begin
					cur = pending_cmds.pop_front();
					start <= 1'b1;
					func <= cur.fn;
					point_x_mm <= cur.x;
					point_y_mm <= cur.y;
					point_z_mm <= cur.z;
					cell_col <= cur.col;
					cell_row <= cur.row;
				end else begin
					start <= 1'b0;
				end
			end else if (!start) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_cmds.size() > 0) begin
					cur = pending_cmds.pop_front();
					start <= 1'b1;
					func <= cur.fn;
					point_x_mm <= cur.x;
					point_y_mm <= cur.y;
					point_z_mm <= cur.z;
					cell_col <= cur.col;
					cell_row <= cur.row;
				end
			end
		end
	end

	// result checker, command prediction and watchdog
	always @(posedge clk) begin
		map_res_t e;
		bit progress;
		progress = 0;
		if (arst_n && done) begin
			progress = 1;
			n_done++;
			if (expected_maps.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result: cell %0d status %0d", cell_value, status);
				end
			end else begin
				e = expected_maps.pop_front();
				if (cell_value !== e.cval || map_width !== e.w || map_height !== e.h ||
				    origin_x_mm !== e.ox || origin_y_mm !== e.oy || status !== e.st) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("mismatch at result %0d: exp cell %0d w %0d h %0d ox %0d oy %0d st %0d",
						         n_done, e.cval, e.w, e.h, $signed(e.ox), $signed(e.oy), e.st);
						$display("                      got cell %0d w %0d h %0d ox %0d oy %0d st %0d",
						         cell_value, map_width, map_height, origin_x_mm, origin_y_mm,
						         status);
					end
				end
			end
		end
		if (arst_n && start && !busy) begin
			progress = 1;
			predict_map(cur);
			n_acc++;
			burst = ((n_acc / 150) % 3) == 0;
		end
		if (progress) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_cmd(input logic [2:0] fn, input int x, input int y, input int z,
	                       input int col, input int row);
		cmd_t c;
		c.fn = fn;
		c.x = x[23:0];
		c.y = y[23:0];
		c.z = z[23:0];
		c.col = col[7:0];
		c.row = row[7:0];
		pending_cmds = {pending_cmds, c};
		n_pushed++;
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || n_acc != n_pushed || expected_maps.size() != 0 || busy);
	endtask

	task automatic reg_write(input logic [2:0] idx, input int val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RES:       cfg_res = val & 'h3FF;
			REG_PAD:       cfg_pad = val & 'h3FFF;
			REG_FLOOR_LO:  cfg_flo = int'($signed(val[17:0]));
			REG_FLOOR_HI:  cfg_fhi = int'($signed(val[17:0]));
			REG_OBST_LO:   cfg_olo = int'($signed(val[17:0]));
			REG_OBST_HI:   cfg_ohi = int'($signed(val[17:0]));
			REG_FREE_GROW: cfg_fgrow = val & 'h3FFF;
			REG_OBST_GROW: cfg_ogrow = val & 'h3FFF;
			default: ;
		endcase
	endtask

	task automatic set_config(input int res, input int pad, input int flo, input int fhi,
	                          input int olo, input int ohi, input int fg, input int og);
		wait_idle();
		reg_write(REG_RES, res);
		reg_write(REG_PAD, pad);
		reg_write(REG_FLOOR_LO, flo);
		reg_write(REG_FLOOR_HI, fhi);
		reg_write(REG_OBST_LO, olo);
		reg_write(REG_OBST_HI, ohi);
		reg_write(REG_FREE_GROW, fg);
		reg_write(REG_OBST_GROW, og);
		n_settings++;
	endtask

	function automatic int rnd_span(input int s);
		return int'($urandom_range(0, 2 * s)) - s;
	endfunction

	function automatic int pick_z(input int zs);
		case ($urandom_range(0, 11))
			0: return cfg_flo;
			1: return cfg_fhi;
			2: return cfg_olo;
			3: return cfg_ohi;
			4: return cfg_flo - 1;
			5: return cfg_ohi + 1;
			default: return rnd_span(zs);
		endcase
	endfunction

	// one map: clear, bounds pass, bin pass with noise, late box growth, build, reads
	task automatic run_map(input int xy, input int zs, input int late_xy, input int n_bounds,
	                       input int n_bins, input int n_reads);
		int span_c;
		add_cmd(FN_CLEAR, 0, 0, 0, 0, 0);
		repeat (n_bounds) add_cmd(FN_BOUNDS, rnd_span(xy), rnd_span(xy), rnd_span(zs), 0, 0);
		repeat (n_bins) begin
			case ($urandom_range(0, 24))
				0: add_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
				           $urandom, $urandom);
				1: add_cmd(FN_BIN, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: add_cmd(FN_BIN, rnd_span(xy + xy / 8), rnd_span(xy + xy / 8),
				                 pick_z(zs), 0, 0);
			endcase
		end
		repeat (4) add_cmd(FN_BOUNDS, rnd_span(late_xy), rnd_span(late_xy), 0, 0, 0);
		add_cmd(FN_BUILD, $urandom, $urandom, $urandom, $urandom, $urandom);
		span_c = (2 * late_xy + 2 * cfg_pad) / int'(res_eff()) + 3;
		if (span_c > 255) span_c = 255;
		repeat (n_reads) begin
			if ($urandom_range(0, 4) == 0)
				add_cmd(FN_READ, $urandom, $urandom, $urandom, $urandom_range(0, 255),
				        $urandom_range(0, 255));
			else
				add_cmd(FN_READ, 0, 0, 0, $urandom_range(0, span_c), $urandom_range(0, span_c));
		end
	endtask

	initial begin
		int flo, olo;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty box cases, unused codes, extremes, saturated grid
		set_config(50, 500, -300, 50, 50, 1200, 100, 300);
		add_cmd(FN_CLEAR, 0, 0, 0, 0, 0);
		add_cmd(FN_BIN, 100, 100, 0, 0, 0);
		add_cmd(FN_BUILD, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 0, 255, 255);
		add_cmd(3'd5, -8388608, 8388607, -8388608, 255, 0);
		add_cmd(3'd6, 8388607, -8388608, 8388607, 0, 255);
		add_cmd(3'd7, -1, -1, -1, 255, 255);
		add_cmd(FN_BOUNDS, -8388608, 8388607, 0, 0, 0);
		add_cmd(FN_BOUNDS, 8388607, -8388608, 0, 0, 0);
		add_cmd(FN_BIN, -8388608, -8388608, 0, 0, 0);
		add_cmd(FN_BIN, -8388600, -8388000, 600, 0, 0);
		add_cmd(FN_BIN, 8388607, -8388608, 8388607, 0, 0);
		add_cmd(FN_BIN, -8388608, 8388607, -8388608, 0, 0);
		add_cmd(FN_BUILD, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 0, 0, 0);
		add_cmd(FN_READ, 0, 0, 0, 10, 12);
		add_cmd(FN_READ, 0, 0, 0, 255, 255);
		add_cmd(FN_READ, 0, 0, 0, 3, 0);

		// random maps over several register settings, extremes among them
		set_config(50, 500, -300, 50, 50, 1200, 100, 300);
		run_map(3000, 1500, 3750, 40, 220, 100);
		set_config(1000, 10000, -100000, 0, 0, 100000, 10000, 10000);
		run_map(100000, 120000, 100000, 30, 120, 120);
		set_config(1, 0, -20, 20, 10, 60, 0, 0);
		run_map(100, 80, 1000, 30, 200, 100);
		set_config(0, 0, -50, 50, -10, 30, 10000, 10000);
		run_map(60, 70, 60, 20, 25, 100);
		repeat (2) begin
			flo = -int'($urandom_range(0, 500));
			olo = int'($urandom_range(0, 400)) - 100;
			set_config($urandom_range(20, 200), $urandom_range(0, 2000), flo,
			           flo + int'($urandom_range(0, 500)), olo, olo + int'($urandom_range(0, 1500)),
			           $urandom_range(0, 600), $urandom_range(0, 600));
			run_map(int'($urandom_range(2000, 4000)), 1200, 4500, 40, 230, 100);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		errors += expected_maps.size();
		$display("ran %0d commands with %0d results checked over %0d register settings",
		         n_acc, n_done, n_settings);
		$display("mismatches and missing results: %0d", errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
